FILE: hdl/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int SPQ_DEPTH = 16;
  localparam int PRIO_W    = 8;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic                     valid;
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

endpackage

FILE: hdl/spq_cell.sv
// one cell of the sorted chain: holds one entry, shifts right on insert, left on remove
module spq_cell (
  input  logic            clk,
  input  logic            rst,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left,
  input  logic            left_stay,
  input  spq_pkg::entry_t right,
  output spq_pkg::entry_t ent,
  output logic            stay
);
  import spq_pkg::*;

  entry_t ent_next;

  assign stay = ent.valid && (ent.prio <= cmd.prio);

  always_comb begin
    ent_next = ent;
    if (cmd.ins) begin
      if (stay) begin
        ent_next = ent;
      end else if (left_stay) begin
        ent_next.valid = 1'b1;
        ent_next.prio  = cmd.prio;
        ent_next.data  = cmd.data;
      end else begin
        ent_next = left;
      end
    end else if (cmd.rem) begin
      ent_next = right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.prio <= ent_next.prio;
    ent.data <= ent_next.data;
  end

endmodule

FILE: hdl/sorted_insert_priority_queue_core.sv
// top level of the sorted priority queue: cell chain, entry count and result register
//
//   channel | handshake          | fields
//   in      | in_valid, in_stall  | opcode, priority_req, payload
//   out     | out_valid, out_stall| status, out_priority, out_payload, occupancy
//
// one beat per cycle while the output is not stalled: every cell updates from its neighbors in the same cycle
// the result is registered and appears in the cycle after the input beat
// a new input beat is taken while the result register is empty or being drained
// reset clears the cell valid bits and the count; entry contents are not reset
module sorted_insert_priority_queue_core #(
  parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  spq_pkg::opcode_t                         opcode,
  input  logic [spq_pkg::PRIO_W-1:0]               priority_req,
  input  logic signed [spq_pkg::DATA_W-1:0]        payload,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output spq_pkg::status_t                         status,
  output logic [spq_pkg::PRIO_W-1:0]               out_priority,
  output logic signed [spq_pkg::DATA_W-1:0]        out_payload,
  output logic [spq_pkg::OCC_W-1:0]                occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  entry_t           cells [DEPTH];
  logic             stay_vec [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  cmd_t             cmd;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW+OCC_W-1:0] count_ext;
  logic             fire;
  logic             full;
  logic             empty;
  logic             out_fire;

  assign out_fire = out_valid && !out_stall;
  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;
  assign full     = valid_vec[DEPTH-1];
  assign empty    = !valid_vec[0];

  assign cmd.ins  = fire && (opcode == OP_INSERT) && !full;
  assign cmd.rem  = fire && (opcode == OP_REMOVE) && !empty;
  assign cmd.prio = priority_req;
  assign cmd.data = payload;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left;
    logic   left_stay;
    entry_t right;

    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_stay = 1'b1;
    end else begin : g_mid
      assign left      = cells[i-1];
      assign left_stay = stay_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cells[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left      (left),
      .left_stay (left_stay),
      .right     (right),
      .ent       (cells[i]),
      .stay      (stay_vec[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.rem) begin
      count_next = count - CW'(1);
    end
  end

  assign count_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      occupancy    <= count_ext[OCC_W-1:0];
      out_priority <= '0;
      out_payload  <= '0;
      if (opcode == OP_INSERT) begin
        status <= full ? ST_FULL : ST_INSERTED;
      end else if (empty) begin
        status <= ST_EMPTY;
      end else begin
        status       <= ST_REMOVED;
        out_priority <= cells[0].prio;
        out_payload  <= cells[0].data;
      end
    end
  end

  // count tracks the number of valid cells
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == count)
    else $error("entry count differs from valid cells");

  // valid cells form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("valid cells not contiguous");

  // a successful remove drops the count by one
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    cmd.rem |=> count == $past(count) - CW'(1))
    else $error("remove did not drop count");

  // a rejected insert leaves the chain untouched
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    fire && (opcode == OP_INSERT) && full |=> $stable(valid_vec) && (count == $past(count)))
    else $error("full insert changed the queue");

endmodule

FILE: dv/sorted_insert_priority_queue_core_test.sv
// testbench for the sorted priority queue core: directed and random traffic against a mirror queue
`timescale 1ns / 1ps

module sorted_insert_priority_queue_core_test;
  import spq_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    status_t                  st;
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
    logic [OCC_W-1:0]         occ;
  } queue_outcome_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  opcode_t                  opcode;
  logic [PRIO_W-1:0]        priority_req;
  logic signed [DATA_W-1:0] payload;
  logic                     out_valid;
  logic                     out_stall;
  status_t                  status;
  logic [PRIO_W-1:0]        out_priority;
  logic signed [DATA_W-1:0] out_payload;
  logic [OCC_W-1:0]         occupancy;

  // mirror of the queue contents, head at index 0
  logic [PRIO_W-1:0]        mirror_prio [SPQ_DEPTH];
  logic signed [DATA_W-1:0] mirror_data [SPQ_DEPTH];
  int                       mirror_count;
  int                       peak_count;

  queue_outcome_t outcome_fifo[$];
  queue_outcome_t want;

  int  errors;
  int  beats_sent;
  int  status_seen [4];
  int  idle_cycles;
  int  holds_asked;
  int  holds_done;
  bit  rx_holding;
  bit  tx_gaps_on;
  bit  rx_gaps_on;
  bit  valid_held;

  sorted_insert_priority_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .priority_req (priority_req),
    .payload      (payload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .occupancy    (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic mirror_queue_op(opcode_t op, logic [PRIO_W-1:0] pr,
                                 logic signed [DATA_W-1:0] pl);
    queue_outcome_t o;
    int pos;
    o.st   = ST_INSERTED;
    o.prio = '0;
    o.data = '0;
    if (op == OP_INSERT) begin
      if (mirror_count >= SPQ_DEPTH) begin
        o.st = ST_FULL;
      end else begin
        pos = 0;
        // equal priorities go behind the ones already stored
        while (pos < mirror_count && mirror_prio[pos] <= pr) pos++;
        for (int k = mirror_count; k > pos; k--) begin
          mirror_prio[k] = mirror_prio[k-1];
          mirror_data[k] = mirror_data[k-1];
        end
        mirror_prio[pos] = pr;
        mirror_data[pos] = pl;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        o.st = ST_EMPTY;
      end else begin
        o.st   = ST_REMOVED;
        o.prio = mirror_prio[0];
        o.data = mirror_data[0];
        for (int k = 1; k < mirror_count; k++) begin
          mirror_prio[k-1] = mirror_prio[k];
          mirror_data[k-1] = mirror_data[k];
        end
        mirror_count--;
      end
    end
    if (mirror_count > peak_count) peak_count = mirror_count;
    o.occ = OCC_W'(mirror_count);
    outcome_fifo.push_back(o);
  endtask

  // called at a rising edge; returns at the edge that accepts the beat, plus any gap
  task automatic send_beat(opcode_t op, logic [PRIO_W-1:0] pr,
                           logic signed [DATA_W-1:0] pl);
    int gap;
    in_valid     <= 1'b1;
    opcode       <= op;
    priority_req <= pr;
    payload      <= pl;
    do @(posedge clk); while (in_stall);
    mirror_queue_op(op, pr, pl);
    beats_sent++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid   <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      valid_held = 1'b1;
    end
  endtask

  task automatic stop_sending();
    if (valid_held) begin
      in_valid   <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  task automatic wait_drained();
    stop_sending();
    while (outcome_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int ins_pct, int plo, int phi);
    if ($urandom_range(0, 99) < ins_pct)
      send_beat(OP_INSERT, PRIO_W'($urandom_range(plo, phi)), $urandom);
    else
      send_beat(OP_REMOVE, PRIO_W'($urandom), $urandom);
  endtask

  task automatic test_empty_and_extremes();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    send_beat(OP_REMOVE, 8'hff, 32'hffff_ffff);
    send_beat(OP_INSERT, 8'hff, 32'sh7fff_ffff);
    send_beat(OP_INSERT, 8'h00, 32'sh8000_0000);
    send_beat(OP_INSERT, 8'h80, -32'sd1);
    send_beat(OP_INSERT, 8'h01, 32'sd0);
    repeat (5) send_beat(OP_REMOVE, 8'h00, 32'sd0);
    wait_drained();
  endtask

  task automatic test_equal_priority_order();
    send_beat(OP_INSERT, 8'd7, 32'sh1111_1111);
    send_beat(OP_INSERT, 8'd7, 32'sh2222_2222);
    send_beat(OP_INSERT, 8'd3, 32'sh3333_3333);
    send_beat(OP_INSERT, 8'd7, 32'sh4444_4444);
    repeat (4) send_beat(OP_REMOVE, 8'd0, 32'sd0);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    repeat (SPQ_DEPTH + 2) send_beat(OP_INSERT, PRIO_W'($urandom), $urandom);
    repeat (SPQ_DEPTH + 1) send_beat(OP_REMOVE, PRIO_W'($urandom), $urandom);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          tx_gaps_on = 1'b1; rx_gaps_on = 1'b1;
          repeat (50) send_random(70, 0, 255);
        end
        1: begin
          repeat (50) send_random(30, 0, 255);
        end
        2: begin
          tx_gaps_on = 1'b0; rx_gaps_on = 1'b0;
          repeat (50) send_random(55, 0, 3);
        end
        3: begin
          tx_gaps_on = 1'b1; rx_gaps_on = 1'b1;
          repeat (50) send_random(80, 0, 255);
        end
        4: begin
          repeat (50) send_random(50, 252, 255);
        end
        default: begin
          tx_gaps_on = 1'b0;
          repeat (50) send_random(20, 0, 255);
        end
      endcase
    end
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    holds_asked++;
    while (!rx_holding) @(posedge clk);
    repeat (40) send_random(60, 0, 255);
    wait_drained();
  endtask

  // receiver side: random stalls plus a long hold on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        rx_holding = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        rx_holding = 1'b0;
        holds_done++;
      end else if (rx_gaps_on) begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      status_seen[status]++;
      if (outcome_fifo.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual status %s",
                 $time, status.name());
        errors++;
      end else begin
        want = outcome_fifo.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %s actual %s", $time, want.st.name(), status.name());
          errors++;
        end
        if (out_priority !== want.prio) begin
          $display("%0t: out_priority expected %0d actual %0d", $time, want.prio, out_priority);
          errors++;
        end
        if (out_payload !== want.data) begin
          $display("%0t: out_payload expected %h actual %h", $time, want.data, out_payload);
          errors++;
        end
        if (occupancy !== want.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    opcode       <= OP_INSERT;
    priority_req <= '0;
    payload      <= '0;
    idle_cycles  <= 0;
    errors       = 0;
    beats_sent   = 0;
    mirror_count = 0;
    peak_count   = 0;
    holds_asked  = 0;
    holds_done   = 0;
    rx_holding   = 1'b0;
    tx_gaps_on   = 1'b0;
    rx_gaps_on   = 1'b0;
    valid_held   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_extremes();
    test_equal_priority_order();
    test_fill_to_full();
    test_random_traffic();
    test_output_hold_off();

    repeat (5) @(posedge clk);
    $display("covered %0d beats: %0d inserts, %0d full rejects, %0d removes, %0d empty removes",
             beats_sent, status_seen[ST_INSERTED], status_seen[ST_FULL],
             status_seen[ST_REMOVED], status_seen[ST_EMPTY]);
    $display("peak occupancy %0d of %0d, one long output hold-off, %0d mismatches",
             peak_count, SPQ_DEPTH, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
